FILE: design/optt_pkg.sv
// Shared types and constants for the timer table.
package optt_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [31:0] ONESHOT_BASE = 32'd1000;
    localparam logic [31:0] PERIODIC_BASE = 32'hFFFF_FC18;
    localparam logic signed [31:0] ID_MAX = 32'sd2147483645;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_ONESHOT = 2'd1,
        MODE_PERIOD  = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FIRE  = 2'd2;

    // Command word passed from front to back.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [31:0] user_value;
        logic [31:0] target_id;
    } t_cmd;

endpackage

FILE: design/oneshot_periodic_timer_table.sv
// Top level of the timer table: command queue in front, slot engine behind.
//
//   channel   direction  handshake          payload
//   command   in         i_push / o_full    mode now_ms period_ms user_value target_id
//   result    out        o_empty / i_pop    kind timer_id fired_value done_ok active_count last
//
// A tick scans one slot per cycle, stalling while a fire waits to be popped.
// A set scans for a free slot, then checks each id candidate against every slot.
// A clear scans the slots for the target id; clear of all empties the table without a scan.
// Reset is synchronous and empties the table and the command queue.
// Each fire of a tick is held one slot behind, so the final one leaves flagged last.
module oneshot_periodic_timer_table
    import optt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_period_ms,
    input  logic signed [31:0] i_user_value,
    input  logic signed [31:0] i_target_id,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic signed [31:0] o_timer_id,
    output logic signed [31:0] o_fired_value,
    output logic        o_done_ok,
    output logic [4:0]  o_active_count,
    output logic        o_last
);

    t_cmd w_wdata, w_rdata;
    logic w_cmd_empty, w_cmd_pop;

    assign w_wdata = '{mode: i_mode, now_ms: i_now_ms, period_ms: i_period_ms,
                       user_value: i_user_value, target_id: i_target_id};

    optt_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(i_push), .i_wdata(w_wdata), .o_full(o_full),
        .i_rd(w_cmd_pop), .o_rdata(w_rdata), .o_empty(w_cmd_empty)
    );

    optt_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_rdata), .i_cmd_empty(w_cmd_empty), .o_cmd_pop(w_cmd_pop),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_kind(o_kind), .o_timer_id(o_timer_id), .o_fired_value(o_fired_value),
        .o_done_ok(o_done_ok), .o_active_count(o_active_count), .o_last(o_last)
    );

endmodule

FILE: design/optt_cmd_fifo.sv
// Command queue between the front and back parts.
module optt_cmd_fifo
    import optt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty
);

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    // Store a word.
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) r_wp <= r_wp + 1'b1;
            if (i_rd && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_wr && !o_full) - (FIFO_AW+1)'(i_rd && !o_empty);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("fifo overflow");
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wp == r_rp)) else $error("fifo pointers disagree");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full) else $error("fifo lost a word");
`endif

endmodule

FILE: design/optt_engine.sv
// Back part: scans the slot table one slot a cycle, holding while a result waits to be popped, and produces results.
module optt_engine
    import optt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_empty,
    output logic        o_cmd_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [31:0] o_timer_id,
    output logic [31:0] o_fired_value,
    output logic        o_done_ok,
    output logic [4:0]  o_active_count,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_FREE, S_IDSTEP, S_IDCHK, S_CLEAR, S_EMIT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [SLOT_W:0] r_idx;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_periodic;
    logic [31:0] r_ident [SLOTS];
    logic [31:0] r_start [SLOTS];
    logic [31:0] r_period [SLOTS];
    logic [31:0] r_user [SLOTS];
    logic [31:0] r_next_os, r_next_pd, r_cand;
    logic [CNT_W-1:0] r_count;
    logic [SLOT_W-1:0] r_free;
    logic r_found;
    // fire held back one slot so the final one can be flagged last
    logic [31:0] r_pid, r_pval;
    logic [4:0] r_pacnt;
    // output register
    logic r_ovalid;
    logic [1:0] r_kind;
    logic [31:0] r_id, r_val;
    logic r_ok, r_last;
    logic [4:0] r_acnt;

    logic [SLOT_W-1:0] w_i;
    logic w_out_free, w_end, w_expired, w_match;
    logic w_tick_adv, w_clr_hit, w_load;
    logic [31:0] w_elapsed;
    logic [CNT_W-1:0] w_cnt_dec;

    assign w_i = r_idx[SLOT_W-1:0];
    assign w_end = (r_idx == (SLOT_W+1)'(SLOTS - 1));
    assign w_out_free = !r_ovalid || i_pop;
    assign w_elapsed = r_cmd.now_ms - r_start[w_i];
    assign w_expired = r_valid[w_i] && !r_period[w_i][31] && (w_elapsed >= r_period[w_i]);
    assign w_match = r_valid[w_i] && (r_ident[w_i] == r_cand);
    assign w_cnt_dec = (r_count != '0) ? r_count - 1'b1 : r_count;
    assign w_tick_adv = !(w_expired && r_found) || w_out_free;
    assign w_clr_hit = r_valid[w_i] && (r_ident[w_i] == r_cmd.target_id) && !r_found;

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_empty = !r_ovalid;
    assign o_kind = r_kind;
    assign o_timer_id = r_id;
    assign o_fired_value = r_val;
    assign o_done_ok = r_ok;
    assign o_active_count = r_acnt;
    assign o_last = r_last;

    // Flag the cycles that load a word into the output register.
    always_comb begin
        w_load = 1'b0;
        case (r_state)
            S_TICK:  w_load = w_out_free && w_expired && r_found;
            S_EMIT:  w_load = w_out_free && r_found;
            S_FREE:  w_load = w_out_free && r_valid[w_i] && w_end;
            S_IDCHK: w_load = w_out_free && !w_match && w_end;
            S_CLEAR: w_load = w_out_free && ((r_cmd.target_id == '0) ||
                                             (!w_clr_hit && (w_end || r_found)));
            default: w_load = 1'b0;
        endcase
    end

    // Slot payload: written on a set or on a periodic restart.
    always_ff @(posedge i_clk) begin
        if (r_state == S_TICK && w_tick_adv && w_expired && r_periodic[w_i]) begin
            r_start[w_i] <= r_cmd.now_ms;
        end
        if (r_state == S_IDCHK && w_end && !w_match && w_out_free) begin
            r_periodic[r_free] <= (r_cmd.mode == MODE_PERIOD);
            r_ident[r_free] <= r_cand;
            r_start[r_free] <= r_cmd.now_ms;
            r_period[r_free] <= r_cmd.period_ms;
            r_user[r_free] <= r_cmd.user_value;
        end
    end

    // Sequencer, slot valid bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_next_os <= ONESHOT_BASE;
            r_next_pd <= PERIODIC_BASE;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        case (i_cmd.mode)
                            MODE_TICK: r_state <= S_TICK;
                            MODE_CLEAR: r_state <= S_CLEAR;
                            default: r_state <= S_FREE;
                        endcase
                    end
                end
                S_TICK: begin
                    // One slot a cycle; hold when a held fire must leave and cannot.
                    if (w_tick_adv) begin
                        if (w_expired) begin
                            if (r_found) begin
                                r_kind <= KIND_FIRE;
                                r_id <= r_pid;
                                r_val <= r_pval;
                                r_ok <= 1'b0;
                                r_acnt <= r_pacnt;
                                r_last <= 1'b0;
                            end
                            r_pid <= r_ident[w_i];
                            r_pval <= r_user[w_i];
                            if (r_periodic[w_i]) begin
                                r_pacnt <= 5'(r_count);
                            end else begin
                                r_valid[w_i] <= 1'b0;
                                r_count <= w_cnt_dec;
                                r_pacnt <= 5'(w_cnt_dec);
                            end
                            r_found <= 1'b1;
                        end
                        if (w_end) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    // Send the held fire flagged last, if the tick found any.
                    if (!r_found) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_kind <= KIND_FIRE;
                        r_id <= r_pid;
                        r_val <= r_pval;
                        r_ok <= 1'b0;
                        r_acnt <= r_pacnt;
                        r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FREE: begin
                    if (!r_valid[w_i]) begin
                        r_free <= w_i;
                        r_found <= 1'b1;
                        r_state <= S_IDSTEP;
                    end else if (w_end) begin
                        if (w_out_free) begin
                            r_kind <= KIND_SET;
                            r_id <= '0;
                            r_val <= '0;
                            r_ok <= 1'b0;
                            r_acnt <= 5'(r_count);
                            r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDSTEP: begin
                    // Advance the candidate id with wrap.
                    if (r_cmd.mode == MODE_ONESHOT) begin
                        r_cand <= ($signed(r_next_os) > ID_MAX) ?
                            ONESHOT_BASE + 32'd1 : r_next_os + 32'd1;
                    end else begin
                        r_cand <= ($signed(r_next_pd) < -ID_MAX) ?
                            PERIODIC_BASE - 32'd1 : r_next_pd - 32'd1;
                    end
                    r_idx <= '0;
                    r_state <= S_IDCHK;
                end
                S_IDCHK: begin
                    if (w_match) begin
                        if (r_cmd.mode == MODE_ONESHOT) r_next_os <= r_cand;
                        else r_next_pd <= r_cand;
                        r_state <= S_IDSTEP;
                    end else if (w_end) begin
                        if (w_out_free) begin
                            if (r_cmd.mode == MODE_ONESHOT) r_next_os <= r_cand;
                            else r_next_pd <= r_cand;
                            r_valid[r_free] <= 1'b1;
                            r_count <= r_count + 1'b1;
                            r_kind <= KIND_SET;
                            r_id <= r_cand;
                            r_val <= '0;
                            r_ok <= 1'b1;
                            r_acnt <= 5'(r_count + 1'b1);
                            r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CLEAR: begin
                    if (r_cmd.target_id == '0) begin
                        if (w_out_free) begin
                            r_valid <= '0;
                            r_count <= '0;
                            r_kind <= KIND_CLEAR;
                            r_id <= '0;
                            r_val <= '0;
                            r_ok <= 1'b1;
                            r_acnt <= '0;
                            r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (w_clr_hit) begin
                        r_valid[w_i] <= 1'b0;
                        r_count <= w_cnt_dec;
                        r_found <= 1'b1;
                    end else if (w_end || r_found) begin
                        if (w_out_free) begin
                            r_kind <= KIND_CLEAR;
                            r_id <= r_cmd.target_id;
                            r_val <= '0;
                            r_ok <= 1'b1;
                            r_acnt <= 5'(r_count);
                            r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS)) else $error("count beyond table size");
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count == CNT_W'($countones(r_valid))))
        else $error("count disagrees with valid bits");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state != S_IDLE)) else $error("command dropped");
`endif

endmodule

FILE: tb/oneshot_periodic_timer_table_tb.sv
// Self-checking testbench for the timer table: directed table, then random commands.
module oneshot_periodic_timer_table_tb;
    import optt_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] id;
        logic signed [31:0] val;
        logic               ok;
        logic [4:0]         cnt;
        logic               last;
    } t_res;

    typedef struct {
        logic [1:0]         mode;
        logic [31:0]        now;
        logic [31:0]        period;
        logic signed [31:0] user;
        logic signed [31:0] target;
        bit                 typed;
        t_res               res;
    } t_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic [1:0]         i_mode = MODE_TICK;
    logic [31:0]        i_now_ms = '0;
    logic [31:0]        i_period_ms = '0;
    logic signed [31:0] i_user_value = '0;
    logic signed [31:0] i_target_id = '0;
    logic               i_pop = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic [1:0]         o_kind;
    logic signed [31:0] o_timer_id;
    logic signed [31:0] o_fired_value;
    logic               o_done_ok;
    logic [4:0]         o_active_count;
    logic               o_last;

    // Timer shadow state
    bit          tmr_valid [SLOTS];
    bit          tmr_periodic [SLOTS];
    logic [31:0] tmr_ident [SLOTS];
    logic [31:0] tmr_start [SLOTS];
    logic [31:0] tmr_period [SLOTS];
    logic [31:0] tmr_user [SLOTS];
    logic [31:0] oneshot_ctr = ONESHOT_BASE;
    logic [31:0] periodic_ctr = PERIODIC_BASE;
    logic [4:0]  live_count = '0;

    t_res expected_words [$];
    t_row rows [$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    bit   timed_out = 1'b0;
    bit   accepted_cycle;
    bit   stim_done = 1'b0;

    oneshot_periodic_timer_table u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_mode         (i_mode),
        .i_now_ms       (i_now_ms),
        .i_period_ms    (i_period_ms),
        .i_user_value   (i_user_value),
        .i_target_id    (i_target_id),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_kind         (o_kind),
        .o_timer_id     (o_timer_id),
        .o_fired_value  (o_fired_value),
        .o_done_ok      (o_done_ok),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit ident_live(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tmr_valid[i] && tmr_ident[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_res mk_res(logic [1:0] kind, logic [31:0] id, logic [31:0] val,
                                    logic ok);
        t_res r;
        r.kind = kind;
        r.id = id;
        r.val = val;
        r.ok = ok;
        r.cnt = live_count;
        r.last = 1'b0;
        return r;
    endfunction

    // Compute the result words of one command and advance the shadow table
    task automatic predict_timers(input logic [1:0] mode, input logic [31:0] now,
                                  input logic [31:0] period, input logic [31:0] user,
                                  input logic [31:0] target, ref t_res words [$]);
        int     free_slot;
        longint c;
        logic [31:0] id;
        words.delete();
        if (mode == MODE_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!tmr_valid[i] || tmr_period[i][31]) continue;
                if (32'(now - tmr_start[i]) < tmr_period[i]) continue;
                if (tmr_periodic[i]) begin
                    tmr_start[i] = now;
                end else begin
                    tmr_valid[i] = 1'b0;
                    if (live_count > 0) live_count--;
                end
                words.push_back(mk_res(KIND_FIRE, tmr_ident[i], tmr_user[i], 1'b0));
            end
        end else if (mode == MODE_ONESHOT || mode == MODE_PERIOD) begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!tmr_valid[i]) begin
                    free_slot = i;
                    break;
                end
            if (free_slot < 0) begin
                words.push_back(mk_res(KIND_SET, '0, '0, 1'b0));
            end else begin
                if (mode == MODE_ONESHOT) begin
                    c = longint'($signed(oneshot_ctr));
                    do begin
                        if (c > longint'(ID_MAX)) c = longint'(ONESHOT_BASE);
                        c++;
                    end while (ident_live(32'(c)));
                    oneshot_ctr = 32'(c);
                    id = oneshot_ctr;
                end else begin
                    c = longint'($signed(periodic_ctr));
                    do begin
                        if (c < -longint'(ID_MAX)) c = longint'($signed(PERIODIC_BASE));
                        c--;
                    end while (ident_live(32'(c)));
                    periodic_ctr = 32'(c);
                    id = periodic_ctr;
                end
                tmr_valid[free_slot] = 1'b1;
                tmr_periodic[free_slot] = (mode == MODE_PERIOD);
                tmr_ident[free_slot] = id;
                tmr_start[free_slot] = now;
                tmr_period[free_slot] = period;
                tmr_user[free_slot] = user;
                live_count++;
                words.push_back(mk_res(KIND_SET, id, '0, 1'b1));
            end
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (tmr_valid[i] && (target == 0 || tmr_ident[i] == target)) begin
                    tmr_valid[i] = 1'b0;
                    if (live_count > 0) live_count--;
                    if (target != 0) break;
                end
            if (target == 0) live_count = '0;
            words.push_back(mk_res(KIND_CLEAR, target, '0, 1'b1));
        end
        if (words.size() > 0) words[words.size() - 1].last = 1'b1;
    endtask

    // Drive one command word and hold it until accepted
    task automatic send_cmd(input t_row r);
        t_res words [$];
        int   gap;
        i_push <= 1'b1;
        i_mode <= r.mode;
        i_now_ms <= r.now;
        i_period_ms <= r.period;
        i_user_value <= r.user;
        i_target_id <= r.target;
        do @(posedge i_clk); while (o_full);
        predict_timers(r.mode, r.now, r.period, r.user, r.target, words);
        if (r.typed) expected_words.push_back(r.res);
        else foreach (words[k]) expected_words.push_back(words[k]);
        // Insert an idle burst now and then
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_row row_of(logic [1:0] mode, logic [31:0] now, logic [31:0] period,
                                    logic [31:0] user, logic [31:0] target);
        t_row r;
        r.mode = mode;
        r.now = now;
        r.period = period;
        r.user = user;
        r.target = target;
        r.typed = 1'b0;
        r.res = '{default: '0};
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic [1:0] kind, logic [31:0] id,
                                       logic ok, logic [4:0] cnt);
        r.typed = 1'b1;
        r.res = '{kind: kind, id: id, val: '0, ok: ok, cnt: cnt, last: 1'b1};
        return r;
    endfunction

    function automatic logic [31:0] pick_target();
        int live [$];
        for (int i = 0; i < SLOTS; i++)
            if (tmr_valid[i]) live.push_back(i);
        case ($urandom_range(0, 19))
            0: return '0;
            1, 2, 3, 4, 5, 6: return $urandom;
            default: begin
                if (live.size() == 0) return $urandom;
                return tmr_ident[live[$urandom_range(0, live.size() - 1)]];
            end
        endcase
    endfunction

    // Check result words and drive the pop side
    always @(posedge i_clk) begin
        t_res e;
        int   hold;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d id %0d", o_kind, o_timer_id);
            end else begin
                e = expected_words.pop_front();
                if (o_kind !== e.kind || o_timer_id !== e.id || o_fired_value !== e.val ||
                    o_done_ok !== e.ok || o_active_count !== e.cnt || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d id %0d val %0d ok %0d cnt %0d last %0d; got kind %0d id %0d val %0d ok %0d cnt %0d last %0d",
                                 e.kind, e.id, e.val, e.ok, e.cnt, e.last, o_kind,
                                 o_timer_id, o_fired_value, o_done_ok, o_active_count, o_last);
                end
            end
        end
        if (quiet) begin
            i_pop <= 1'b1;
        end else if (hold > 0) begin
            hold--;
            i_pop <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 8);
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Count cycles with work pending but no word moving
    always @(posedge i_clk) begin
        accepted_cycle = (i_push && !o_full) || (i_pop && !o_empty);
        if (accepted_cycle || !i_rst_n || (!i_push && expected_words.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] cur_time;
        logic [1:0]  mode;
        logic [31:0] period;
        int          sel;
        t_row        r;
        for (int i = 0; i < SLOTS; i++) tmr_valid[i] = 1'b0;

        // Directed table
        rows.push_back(typed_row(row_of(MODE_CLEAR, 0, 0, 0, 0), KIND_CLEAR, 0, 1, 0));
        rows.push_back(row_of(MODE_TICK, 0, 0, 0, 0));
        rows.push_back(typed_row(row_of(MODE_ONESHOT, 0, 0, 32'h7FFF_FFFF, 0),
                                 KIND_SET, 1001, 1, 1));
        rows.push_back(typed_row(row_of(MODE_PERIOD, 0, 5, 32'h8000_0000, 0),
                                 KIND_SET, -1001, 1, 2));
        rows.push_back(typed_row(row_of(MODE_ONESHOT, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0),
                                 KIND_SET, 1002, 1, 3));
        rows.push_back(typed_row(row_of(MODE_PERIOD, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF),
                                 KIND_SET, -1002, 1, 4));
        rows.push_back(row_of(MODE_TICK, 0, 0, 0, 0));
        rows.push_back(row_of(MODE_TICK, 5, 0, 0, 0));
        rows.push_back(row_of(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        rows.push_back(typed_row(row_of(MODE_CLEAR, 0, 0, 0, 1002), KIND_CLEAR, 1002, 1, 2));
        rows.push_back(row_of(MODE_CLEAR, 0, 0, 0, 12345));
        rows.push_back(row_of(MODE_CLEAR, 0, 0, 0, 32'h8000_0000));
        for (int k = 0; k < 14; k++)
            rows.push_back(row_of(MODE_ONESHOT, 3, 7, k, 0));
        rows.push_back(typed_row(row_of(MODE_PERIOD, 3, 1, 1, 0), KIND_SET, 0, 0, 16));
        rows.push_back(row_of(MODE_TICK, 10, 0, 0, 0));
        rows.push_back(typed_row(row_of(MODE_CLEAR, 10, 0, 0, 0), KIND_CLEAR, 0, 1, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_cmd(rows[k]);

        // Random commands
        cur_time = 32'd100;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                i_push <= 1'b0;
                while (expected_words.size() != 0) @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            if ($urandom_range(0, 29) == 0) cur_time = $urandom;
            else cur_time = cur_time + $urandom_range(0, 20);
            sel = $urandom_range(0, 99);
            if (sel < 35) mode = MODE_TICK;
            else if (sel < 60) mode = MODE_ONESHOT;
            else if (sel < 80) mode = MODE_PERIOD;
            else mode = MODE_CLEAR;
            sel = $urandom_range(0, 99);
            if (sel < 70) period = $urandom_range(0, 40);
            else if (sel < 85) period = $urandom_range(0, 200);
            else period = $urandom;
            r = row_of(mode, cur_time, period, $urandom,
                       (mode == MODE_CLEAR) ? pick_target() : $urandom);
            send_cmd(r);
        end
        i_push <= 1'b0;
        stim_done = 1'b1;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/optt_pkg.sv
design/optt_cmd_fifo.sv
design/optt_engine.sv
design/oneshot_periodic_timer_table.sv
tb/oneshot_periodic_timer_table_tb.sv
